>>> design/rdfd_pkg.sv
// rdfd_pkg: canvas geometry, opcode codes, parser phases and the result record
// shared by the delta frame decoder; no dependencies

package rdfd_pkg;

    localparam int CANVAS_WIDTH  = 320;
    localparam int CANVAS_HEIGHT = 200;
    localparam int CANVAS_PIXELS = CANVAS_WIDTH * CANVAS_HEIGHT;

    // pixel position holds 0..CANVAS_PIXELS
    localparam int POS_W  = $clog2(CANVAS_PIXELS + 1);
    localparam int PAIR_W = 17;
    localparam int OFF_W  = 16;
    // compare width for counts, doubled counts, room and bytes_after
    localparam int CMP_W  = (POS_W > PAIR_W + 1) ? POS_W : PAIR_W + 1;

    localparam logic [7:0] OP_END_ZERO   = 8'h00;
    localparam logic [7:0] OP_SKIP2      = 8'h02;
    localparam logic [7:0] OP_SKIP8      = 8'h03;
    localparam logic [7:0] OP_SKIP16     = 8'h04;
    localparam logic [7:0] OP_LIT_BIAS   = 8'h05;
    localparam logic [7:0] OP_LIT_FIRST  = 8'h06;
    localparam logic [7:0] OP_LIT_LAST   = 8'h0A;
    localparam logic [7:0] OP_LIT8       = 8'h0B;
    localparam logic [7:0] OP_LIT16      = 8'h0C;
    localparam logic [7:0] OP_FILL_FIRST = 8'h0D;
    localparam logic [7:0] OP_FILL_LAST  = 8'h10;
    localparam logic [7:0] OP_FILL8      = 8'h11;
    localparam logic [7:0] OP_FILL16     = 8'h12;
    localparam logic [7:0] OP_END        = 8'h13;
    localparam logic [7:0] OP_FILL_BIAS  = 8'h0B;

    typedef enum logic [7:0] {
        PH_OPCODE   = 8'b0000_0001,
        PH_COUNT8   = 8'b0000_0010,
        PH_COUNT_LO = 8'b0000_0100,
        PH_COUNT_HI = 8'b0000_1000,
        PH_LIT_A    = 8'b0001_0000,
        PH_LIT_B    = 8'b0010_0000,
        PH_FILL_A   = 8'b0100_0000,
        PH_FILL_B   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic              write_valid;
        logic [OFF_W-1:0]  pixel_offset;
        logic [PAIR_W-1:0] pair_count;
        logic [7:0]        first_value;
        logic [7:0]        second_value;
        logic              frame_end;
        logic              frame_status;
    } t_result;

endpackage

>>> design/rle_delta_frame_decoder.sv
// rle_delta_frame_decoder: top level, byte-wise parser of a delta-coded frame
// with a registered result and a skid stage; depends on rdfd_pkg
//
// an accepted byte's result is registered in the output register, or in the skid stage behind a stalled output
// throughput: one byte per cycle while o_in_stall is low; the parser state is updated in one pass
// o_in_stall rises only when the skid stage holds a result behind a stalled output
// reset (synchronous, active low) clears the parser, pixel position and both valids

module rle_delta_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_bytes_after,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_write_valid,
    output logic [15:0] o_pixel_offset,
    output logic [16:0] o_pair_count,
    output logic [7:0]  o_first_value,
    output logic [7:0]  o_second_value,
    output logic        o_frame_end,
    output logic        o_frame_status
);
    import rdfd_pkg::*;

    localparam logic [POS_W-1:0] PIXELS = POS_W'(CANVAS_PIXELS);

    t_phase              r_phase, n_phase;
    logic [4:0]          r_opcode, n_opcode;
    logic [PAIR_W-1:0]   r_pairs, n_pairs;
    logic [7:0]          r_count_lo, n_count_lo;
    logic [7:0]          r_held, n_held;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_finished, n_finished;

    logic                r_out_valid, r_skid_valid;
    t_result             r_out, r_skid, n_res;

    logic                accept, last, take, res_valid;
    logic                err, stop, done;
    logic [POS_W-1:0]    room;
    logic [CMP_W-1:0]    room_x, half_room, after_x;
    logic [PAIR_W-1:0]   cnt, lit_p, fill_p;
    logic [CMP_W-1:0]    cnt2, lit_p2, pairs2;

    assign accept  = i_in_valid && !o_in_stall;
    assign last    = (i_bytes_after == 16'd0);
    assign room    = PIXELS - r_pos;
    assign room_x  = CMP_W'(room);
    assign half_room = room_x >> 1;
    assign after_x = CMP_W'(i_bytes_after);
    assign lit_p   = PAIR_W'(i_data_byte - OP_LIT_BIAS);
    assign fill_p  = PAIR_W'(i_data_byte - OP_FILL_BIAS);
    assign lit_p2  = CMP_W'({lit_p, 1'b0});
    assign pairs2  = CMP_W'({r_pairs, 1'b0});
    // counted opcodes carry n, the run is n+1 pairs
    assign cnt     = (r_phase == PH_COUNT8) ? PAIR_W'(i_data_byte) + PAIR_W'(1)
                                            : PAIR_W'({i_data_byte, r_count_lo}) + PAIR_W'(1);
    assign cnt2    = CMP_W'({cnt, 1'b0});

    always_comb begin
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_pairs    = r_pairs;
        n_count_lo = r_count_lo;
        n_held     = r_held;
        n_pos      = r_pos;
        n_finished = r_finished;
        err        = 1'b0;
        stop       = 1'b0;
        done       = 1'b0;
        n_res      = '0;

        if (r_finished) begin
            // drain the rest of an ended frame
            if (last) begin
                n_finished = 1'b0;
                n_pos      = '0;
                n_phase    = PH_OPCODE;
                n_opcode   = '0;
                n_pairs    = '0;
                n_count_lo = '0;
                n_held     = '0;
            end
        end else begin
            case (r_phase)
                PH_OPCODE: begin
                    n_opcode = i_data_byte[4:0];
                    case (i_data_byte) inside
                        OP_END_ZERO, OP_END: stop = 1'b1;
                        OP_SKIP2: begin
                            if (room_x < CMP_W'(2)) begin
                                err = 1'b1;
                            end else begin
                                n_pos = r_pos + POS_W'(2);
                                done  = 1'b1;
                            end
                        end
                        OP_SKIP8, OP_LIT8, OP_FILL8: begin
                            if (last) err = 1'b1;
                            else n_phase = PH_COUNT8;
                        end
                        OP_SKIP16, OP_LIT16, OP_FILL16: begin
                            if (i_bytes_after < 16'd2) err = 1'b1;
                            else n_phase = PH_COUNT_LO;
                        end
                        [OP_LIT_FIRST:OP_LIT_LAST]: begin
                            if (after_x < lit_p2 || CMP_W'(lit_p) > half_room) begin
                                err = 1'b1;
                            end else begin
                                n_pairs = lit_p;
                                n_phase = PH_LIT_A;
                            end
                        end
                        [OP_FILL_FIRST:OP_FILL_LAST]: begin
                            if (CMP_W'(fill_p) > half_room || i_bytes_after < 16'd2) begin
                                err = 1'b1;
                            end else begin
                                n_pairs = fill_p;
                                n_phase = PH_FILL_A;
                            end
                        end
                        default: err = 1'b1;
                    endcase
                end
                PH_COUNT8, PH_COUNT_HI: begin
                    if (r_opcode == OP_SKIP8[4:0] || r_opcode == OP_SKIP16[4:0]) begin
                        if (cnt2 > room_x) begin
                            err = 1'b1;
                        end else begin
                            n_pos = POS_W'(CMP_W'(r_pos) + cnt2);
                            done  = 1'b1;
                        end
                    end else if (r_opcode == OP_LIT8[4:0] || r_opcode == OP_LIT16[4:0]) begin
                        if (after_x < cnt2 || CMP_W'(cnt) > half_room) begin
                            err = 1'b1;
                        end else begin
                            n_pairs = cnt;
                            n_phase = PH_LIT_A;
                        end
                    end else begin
                        if (CMP_W'(cnt) > half_room || i_bytes_after < 16'd2) begin
                            err = 1'b1;
                        end else begin
                            n_pairs = cnt;
                            n_phase = PH_FILL_A;
                        end
                    end
                end
                PH_COUNT_LO: begin
                    n_count_lo = i_data_byte;
                    n_phase    = PH_COUNT_HI;
                end
                PH_LIT_A: begin
                    n_held  = i_data_byte;
                    n_phase = PH_LIT_B;
                end
                PH_LIT_B: begin
                    if ((r_pairs > PAIR_W'(1) && last) || r_pairs == '0
                            || room_x < CMP_W'(2)) begin
                        err = 1'b1;
                    end else begin
                        n_res.write_valid  = 1'b1;
                        n_res.pixel_offset = OFF_W'(r_pos);
                        n_res.pair_count   = PAIR_W'(1);
                        n_res.first_value  = r_held;
                        n_res.second_value = i_data_byte;
                        n_pos   = r_pos + POS_W'(2);
                        n_pairs = r_pairs - PAIR_W'(1);
                        if (r_pairs == PAIR_W'(1)) done = 1'b1;
                        else n_phase = PH_LIT_A;
                    end
                end
                PH_FILL_A: begin
                    n_held  = i_data_byte;
                    n_phase = PH_FILL_B;
                end
                PH_FILL_B: begin
                    if (CMP_W'(r_pairs) > half_room) begin
                        err = 1'b1;
                    end else begin
                        n_res.write_valid  = 1'b1;
                        n_res.pixel_offset = OFF_W'(r_pos);
                        n_res.pair_count   = r_pairs;
                        n_res.first_value  = r_held;
                        n_res.second_value = i_data_byte;
                        n_pos   = POS_W'(CMP_W'(r_pos) + pairs2);
                        n_pairs = '0;
                        done    = 1'b1;
                    end
                end
                default: err = 1'b1;
            endcase

            // last byte arrived with an opcode still open
            if (!err && !stop && !done && last) err = 1'b1;

            if (err || stop || (done && last)) begin
                n_res.frame_end    = 1'b1;
                n_res.frame_status = err;
                n_phase    = PH_OPCODE;
                n_opcode   = '0;
                n_pairs    = '0;
                n_count_lo = '0;
                n_held     = '0;
                if (last) begin
                    n_pos      = '0;
                    n_finished = 1'b0;
                end else begin
                    n_finished = 1'b1;
                end
            end else if (done) begin
                n_phase = PH_OPCODE;
            end
        end
    end

    assign res_valid  = accept && (n_res.write_valid || n_res.frame_end);
    assign take       = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OPCODE;
            r_opcode     <= '0;
            r_pairs      <= '0;
            r_count_lo   <= '0;
            r_held       <= '0;
            r_pos        <= '0;
            r_finished   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_opcode   <= n_opcode;
                r_pairs    <= n_pairs;
                r_count_lo <= n_count_lo;
                r_held     <= n_held;
                r_pos      <= n_pos;
                r_finished <= n_finished;
            end
            if (r_skid_valid) begin
                // input is stalled while the skid stage is full
                if (take) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (res_valid) begin
                if (!r_out_valid || take) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_res;
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_valid  = r_out.write_valid;
    assign o_pixel_offset = r_out.pixel_offset;
    assign o_pair_count   = r_out.pair_count;
    assign o_first_value  = r_out.first_value;
    assign o_second_value = r_out.second_value;
    assign o_frame_end    = r_out.frame_end;
    assign o_frame_status = r_out.frame_status;

    a_status_with_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status |-> o_frame_end)
        else $error("frame status set without frame end");

    a_result_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_write_valid || o_frame_end))
        else $error("empty result delivered");

    a_pos_in_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PIXELS)
        else $error("pixel position past canvas end");

    a_finished_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_phase == PH_OPCODE && r_pairs == '0))
        else $error("parser not cleared after frame end");

    a_skid_only_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid stage loaded while output was free");

endmodule

>>> sim/rdfd_result_checker.sv
// rdfd_result_checker: watches the byte and result channels of the delta frame
// decoder, predicts each result from the accepted bytes and compares it
// depends on rdfd_pkg for the opcode codes, parser phases and the result record

module rdfd_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_bytes_after,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_write_valid,
    input  logic [15:0] i_pixel_offset,
    input  logic [16:0] i_pair_count,
    input  logic [7:0]  i_first_value,
    input  logic [7:0]  i_second_value,
    input  logic        i_frame_end,
    input  logic        i_frame_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_writes,
    output int          o_frames_ok,
    output int          o_frames_bad
);
    timeunit 1ns;
    timeprecision 1ps;

    import rdfd_pkg::*;

    localparam int PRINT_CAP = 40;

    t_result     expected_results[$];

    // decoder state as the predictor sees it
    t_phase      parse_state   = PH_OPCODE;
    logic [7:0]  command_op    = '0;
    int unsigned pairs_left    = 0;
    logic [7:0]  count_low     = '0;
    logic [7:0]  held_byte     = '0;
    int unsigned pixel_pos     = 0;
    bit          frame_done    = 1'b0;

    int          fail_total    = 0;
    int          result_total  = 0;
    int          write_total   = 0;
    int          ok_total      = 0;
    int          bad_total     = 0;

    task automatic flag_error(input string msg);
        if (fail_total < PRINT_CAP)
            $display("mismatch at %0t, result %0d: %s", $realtime, result_total, msg);
        fail_total++;
    endtask

    task automatic clear_command();
        parse_state = PH_OPCODE;
        command_op  = '0;
        pairs_left  = 0;
        count_low   = '0;
        held_byte   = '0;
    endtask

    // count of a counted opcode is known: skip now, or arm a literal or fill run
    task automatic open_counted_run(input int unsigned pairs, input int unsigned follow,
                                    input int unsigned room, output bit err,
                                    output bit done);
        err  = 1'b0;
        done = 1'b0;
        if (command_op == OP_SKIP8 || command_op == OP_SKIP16) begin
            if (pairs * 2 > room) begin
                err = 1'b1;
            end else begin
                pixel_pos += pairs * 2;
                done = 1'b1;
            end
        end else if (command_op == OP_LIT8 || command_op == OP_LIT16) begin
            if (follow < pairs * 2 || pairs > room / 2) begin
                err = 1'b1;
            end else begin
                pairs_left  = pairs;
                parse_state = PH_LIT_A;
            end
        end else begin
            if (pairs > room / 2 || follow < 2) begin
                err = 1'b1;
            end else begin
                pairs_left  = pairs;
                parse_state = PH_FILL_A;
            end
        end
    endtask

    task automatic decode_coded_byte(input logic [7:0] b, input logic [15:0] follow_field);
        int unsigned follow;
        int unsigned room;
        int unsigned p;
        bit          last;
        bit          err;
        bit          stop;
        bit          done;
        t_result     r;
        follow = 32'(follow_field);
        last   = (follow == 0);
        err    = 1'b0;
        stop   = 1'b0;
        done   = 1'b0;
        r      = '0;

        // after an early end everything up to the last byte is dropped
        if (frame_done) begin
            if (last) begin
                frame_done = 1'b0;
                pixel_pos  = 0;
                clear_command();
            end
            return;
        end
        if (pixel_pos > CANVAS_PIXELS)
            pixel_pos = CANVAS_PIXELS;
        room = CANVAS_PIXELS - pixel_pos;

        case (parse_state)
            PH_OPCODE: begin
                command_op = b;
                if (b == OP_END_ZERO || b == OP_END) begin
                    stop = 1'b1;
                end else if (b == OP_SKIP2) begin
                    if (room < 2) begin
                        err = 1'b1;
                    end else begin
                        pixel_pos += 2;
                        done = 1'b1;
                    end
                end else if (b == OP_SKIP8 || b == OP_LIT8 || b == OP_FILL8) begin
                    if (follow < 1) err = 1'b1;
                    else parse_state = PH_COUNT8;
                end else if (b == OP_SKIP16 || b == OP_LIT16 || b == OP_FILL16) begin
                    if (follow < 2) err = 1'b1;
                    else parse_state = PH_COUNT_LO;
                end else if (b >= OP_LIT_FIRST && b <= OP_LIT_LAST) begin
                    p = 32'(b - OP_LIT_BIAS);
                    if (follow < p * 2 || p > room / 2) begin
                        err = 1'b1;
                    end else begin
                        pairs_left  = p;
                        parse_state = PH_LIT_A;
                    end
                end else if (b >= OP_FILL_FIRST && b <= OP_FILL_LAST) begin
                    p = 32'(b - OP_FILL_BIAS);
                    if (p > room / 2 || follow < 2) begin
                        err = 1'b1;
                    end else begin
                        pairs_left  = p;
                        parse_state = PH_FILL_A;
                    end
                end else begin
                    err = 1'b1;
                end
            end
            PH_COUNT8: begin
                p = 32'(b);
                open_counted_run(p + 1, follow, room, err, done);
            end
            PH_COUNT_LO: begin
                count_low   = b;
                parse_state = PH_COUNT_HI;
            end
            PH_COUNT_HI: begin
                p = 32'({b, count_low});
                open_counted_run(p + 1, follow, room, err, done);
            end
            PH_LIT_A: begin
                held_byte   = b;
                parse_state = PH_LIT_B;
            end
            PH_LIT_B: begin
                // last byte in the middle of a literal run is a truncation
                if ((pairs_left > 1 && last) || pairs_left == 0 || room < 2) begin
                    err = 1'b1;
                end else begin
                    r.write_valid  = 1'b1;
                    r.pixel_offset = pixel_pos[15:0];
                    r.pair_count   = 17'd1;
                    r.first_value  = held_byte;
                    r.second_value = b;
                    pixel_pos  += 2;
                    pairs_left -= 1;
                    if (pairs_left == 0) done = 1'b1;
                    else parse_state = PH_LIT_A;
                end
            end
            PH_FILL_A: begin
                held_byte   = b;
                parse_state = PH_FILL_B;
            end
            default: begin
                if (pairs_left > room / 2) begin
                    err = 1'b1;
                end else begin
                    r.write_valid  = 1'b1;
                    r.pixel_offset = pixel_pos[15:0];
                    r.pair_count   = pairs_left[16:0];
                    r.first_value  = held_byte;
                    r.second_value = b;
                    pixel_pos  += pairs_left * 2;
                    pairs_left  = 0;
                    done = 1'b1;
                end
            end
        endcase

        if (!err && !stop && !done && last)
            err = 1'b1;

        if (err || stop || (done && last)) begin
            r.frame_end    = 1'b1;
            r.frame_status = err;
            clear_command();
            if (last) begin
                pixel_pos  = 0;
                frame_done = 1'b0;
            end else begin
                frame_done = 1'b1;
            end
        end else if (done) begin
            parse_state = PH_OPCODE;
        end

        if (r.write_valid || r.frame_end)
            expected_results.push_back(r);
    endtask

    task automatic compare_field(input string field_name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            flag_error($sformatf("%s got 0x%0h want 0x%0h", field_name, got, want));
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got = {i_write_valid, i_pixel_offset, i_pair_count, i_first_value,
               i_second_value, i_frame_end, i_frame_status};
        result_total++;
        if (expected_results.size() == 0) begin
            flag_error($sformatf("unexpected result, write %0b end %0b",
                                 got.write_valid, got.frame_end));
            return;
        end
        want = expected_results.pop_front();
        compare_field("write_valid", 32'(got.write_valid), 32'(want.write_valid));
        compare_field("pixel_offset", 32'(got.pixel_offset), 32'(want.pixel_offset));
        compare_field("pair_count", 32'(got.pair_count), 32'(want.pair_count));
        compare_field("first_value", 32'(got.first_value), 32'(want.first_value));
        compare_field("second_value", 32'(got.second_value), 32'(want.second_value));
        compare_field("frame_end", 32'(got.frame_end), 32'(want.frame_end));
        compare_field("frame_status", 32'(got.frame_status), 32'(want.frame_status));
        if (want.write_valid)
            write_total++;
        if (want.frame_end) begin
            if (want.frame_status) bad_total++;
            else ok_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_command();
            pixel_pos  = 0;
            frame_done = 1'b0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                decode_coded_byte(i_data_byte, i_bytes_after);
            if (i_out_valid && !i_out_stall)
                check_result();
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
        o_results    <= result_total;
        o_writes     <= write_total;
        o_frames_ok  <= ok_total;
        o_frames_bad <= bad_total;
    end

endmodule

>>> sim/tb_rle_delta_frame_decoder.sv
// tb_rle_delta_frame_decoder: drives coded frames into the delta frame decoder
// with random gaps and output stalls and gives the verdict
// depends on rdfd_pkg, rle_delta_frame_decoder and rdfd_result_checker

module tb_rle_delta_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import rdfd_pkg::*;

    localparam int         BYTE_TARGET   = 1150;
    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         DRAIN_CYCLES  = 16;
    localparam logic [7:0] OP_UNUSED_LOW = 8'h01;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte    = '0;
    logic [15:0] i_bytes_after  = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic        o_write_valid;
    logic [15:0] o_pixel_offset;
    logic [16:0] o_pair_count;
    logic [7:0]  o_first_value;
    logic [7:0]  o_second_value;
    logic        o_frame_end;
    logic        o_frame_status;

    int          fail_count;
    int          pending_count;
    int          results_seen;
    int          writes_seen;
    int          frames_ok;
    int          frames_bad;

    logic [7:0]  frame_bytes[$];
    int          bytes_sent   = 0;
    int          frames_sent  = 0;
    bit          no_gaps      = 1'b0;
    int          stall_hold   = 0;
    int          stall_roll;
    int          cycle_count  = 0;

    rle_delta_frame_decoder u_dut (.*);

    rdfd_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_bytes_after  (i_bytes_after),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_write_valid  (o_write_valid),
        .i_pixel_offset (o_pixel_offset),
        .i_pair_count   (o_pair_count),
        .i_first_value  (o_first_value),
        .i_second_value (o_second_value),
        .i_frame_end    (o_frame_end),
        .i_frame_status (o_frame_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_results      (results_seen),
        .o_writes       (writes_seen),
        .o_frames_ok    (frames_ok),
        .o_frames_bad   (frames_bad)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cycle limit of %0d reached", CYCLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int rand_in(input int lo, input int hi);
        return $urandom_range(hi, lo);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = rand_in(0, 99);
        if (no_gaps || roll < 55) return 0;
        if (roll < 85) return rand_in(1, 3);
        if (roll < 97) return rand_in(4, 10);
        return rand_in(20, 60);
    endfunction

    // any byte value that is not a known opcode
    function automatic logic [7:0] bad_opcode();
        logic [7:0] op;
        case (rand_in(0, 3))
            0:       op = OP_UNUSED_LOW;
            1:       op = OP_LIT_BIAS;
            default: op = OP_END + 8'(rand_in(1, 236));
        endcase
        return op;
    endfunction

    // receiver side: short stalls, a few long ones, and long free stretches
    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            stall_roll = rand_in(0, 19);
            if (stall_roll < 11) begin
                i_out_stall <= 1'b0;
                stall_hold = rand_in(0, 5);
            end else if (stall_roll < 17) begin
                i_out_stall <= 1'b1;
                stall_hold = rand_in(0, 3);
            end else if (stall_roll < 19) begin
                i_out_stall <= 1'b1;
                stall_hold = rand_in(8, 40);
            end else begin
                i_out_stall <= 1'b0;
                stall_hold = rand_in(50, 200);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic [15:0] follow);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= value;
        i_bytes_after <= follow;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], 16'(frame_bytes.size() - 1 - i));
        frames_sent++;
    endtask

    // random bytes with arbitrary byte counts, closed by a last byte
    task automatic send_noise_frame();
        int len;
        len = rand_in(1, 12);
        for (int i = 0; i < len - 1; i++)
            send_byte(rand_byte(), 16'($urandom_range(16'hffff, 0)));
        send_byte(rand_byte(), '0);
        frames_sent++;
    endtask

    task automatic build_random_frame();
        int         commands;
        int         kind;
        int         k;
        logic [7:0] op;
        frame_bytes.delete();
        commands = rand_in(1, 8);
        repeat (commands) begin
            kind = rand_in(0, 19);
            if (kind == 19) begin
                frame_bytes.push_back(bad_opcode());
            end else if (kind < 2) begin
                frame_bytes.push_back(OP_SKIP2);
            end else if (kind < 4) begin
                frame_bytes.push_back(OP_SKIP8);
                frame_bytes.push_back(rand_byte());
            end else if (kind < 6) begin
                // mostly short skips, now and then one far past the canvas
                k = (rand_in(0, 9) == 0) ? rand_in(0, 255) : rand_in(0, 2);
                frame_bytes.push_back(OP_SKIP16);
                frame_bytes.push_back(rand_byte());
                frame_bytes.push_back(k[7:0]);
            end else if (kind < 10) begin
                k  = rand_in(1, 5);
                op = OP_LIT_BIAS + k[7:0];
                frame_bytes.push_back(op);
                repeat (2 * k) frame_bytes.push_back(rand_byte());
            end else if (kind < 12) begin
                k = (rand_in(0, 29) == 0) ? 255 : rand_in(0, 15);
                frame_bytes.push_back(OP_LIT8);
                frame_bytes.push_back(k[7:0]);
                repeat (2 * (k + 1)) frame_bytes.push_back(rand_byte());
            end else if (kind < 13) begin
                k = rand_in(0, 9);
                frame_bytes.push_back(OP_LIT16);
                frame_bytes.push_back(k[7:0]);
                // a nonzero high byte claims far more data than follows
                if (rand_in(0, 19) == 0) begin
                    frame_bytes.push_back(8'(rand_in(1, 255)));
                end else begin
                    frame_bytes.push_back('0);
                    repeat (2 * (k + 1)) frame_bytes.push_back(rand_byte());
                end
            end else if (kind < 17) begin
                op = OP_FILL_BIAS + 8'(rand_in(2, 5));
                frame_bytes.push_back(op);
                frame_bytes.push_back(rand_byte());
                frame_bytes.push_back(rand_byte());
            end else if (kind == 17) begin
                frame_bytes.push_back(OP_FILL8);
                frame_bytes.push_back(rand_byte());
                frame_bytes.push_back(rand_byte());
                frame_bytes.push_back(rand_byte());
            end else begin
                k = (rand_in(0, 7) == 0) ? rand_in(0, 255) : rand_in(0, 7);
                frame_bytes.push_back(OP_FILL16);
                frame_bytes.push_back(rand_byte());
                frame_bytes.push_back(k[7:0]);
                frame_bytes.push_back(rand_byte());
                frame_bytes.push_back(rand_byte());
            end
        end
        case (rand_in(0, 3))
            0: frame_bytes.push_back(OP_END_ZERO);
            1: begin
                frame_bytes.push_back(OP_END);
                repeat (rand_in(0, 3)) frame_bytes.push_back(rand_byte());
            end
            default: ;
        endcase
        // truncated frame
        if (rand_in(0, 9) == 0 && frame_bytes.size() > 1) begin
            k = rand_in(1, (frame_bytes.size() > 5) ? 4 : frame_bytes.size() - 1);
            repeat (k) void'(frame_bytes.pop_back());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // terminator as the only byte
        frame_bytes = '{OP_END_ZERO};
        send_frame();
        // terminator with bytes left over, those are dropped
        frame_bytes = '{OP_END, 8'h55, 8'hAA};
        send_frame();
        // skip then one literal pair, clean end on the pair
        frame_bytes = '{OP_SKIP2, OP_LIT_FIRST, 8'h00, 8'hFF};
        send_frame();
        // fill that covers the whole canvas
        frame_bytes = '{OP_FILL16, 8'hFF, 8'h7C, 8'h5A, 8'hA5};
        send_frame();
        // skip far past the canvas end
        frame_bytes = '{OP_SKIP16, 8'hFF, 8'hFF, OP_END};
        send_frame();
        // unknown opcode
        frame_bytes = '{OP_UNUSED_LOW, 8'h00};
        send_frame();
        // literal count needs more bytes than follow
        frame_bytes = '{OP_LIT8, 8'h03, 8'h11};
        send_frame();
        // fill opcode as the last byte
        frame_bytes = '{OP_FILL_FIRST};
        send_frame();
        // last byte arrives in the middle of a literal run
        send_byte(OP_LIT_FIRST + 8'd1, 16'd9);
        send_byte(8'h3C, 16'd8);
        send_byte(8'hC3, 16'd0);
        frames_sent++;

        while (bytes_sent < BYTE_TARGET) begin
            no_gaps = (rand_in(0, 4) == 0);
            if (rand_in(0, 19) == 0) begin
                send_noise_frame();
            end else begin
                build_random_frame();
                send_frame();
            end
        end
        no_gaps = 1'b0;
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d coded bytes in %0d frames under random gaps and stalls",
                 bytes_sent, frames_sent);
        $display("checked %0d results: %0d pixel writes, %0d clean ends, %0d malformed",
                 results_seen, writes_seen, frames_ok, frames_bad);
        if (fail_count == 0 && pending_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> rle_delta_frame_decoder.f
design/rdfd_pkg.sv
design/rle_delta_frame_decoder.sv
sim/rdfd_result_checker.sv
sim/tb_rle_delta_frame_decoder.sv
